@@ hw/rtl/nnba_pkg.sv @@
package nnba_pkg;

  localparam int COORD_W           = 13;
  localparam int DIM_REG_W         = 14;
  localparam int OFFSET_W          = 15;
  localparam int IDX_W             = 26;
  localparam int CFG_DATA_W        = 15;
  localparam int CFG_INDEX_W       = 3;
  localparam int MAX_DIMENSION_DEF = 8192;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_DEST_WIDTH    = 3'd2,
    REG_DEST_HEIGHT   = 3'd3,
    REG_OFFSET_X      = 3'd4,
    REG_OFFSET_Y      = 3'd5,
    REG_CANVAS_WIDTH  = 3'd6,
    REG_CANVAS_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] source_index;
    logic [IDX_W-1:0] dest_index;
    logic             write_enable;
  } out_t;

endpackage

@@ hw/rtl/nearest_neighbor_blit_address.sv @@
// Channel    Ports                          Handshake
// ---------  -----------------------------  ------------------------------------
// input      start, busy, in_data           accepted when start && !busy
// result     out_valid, out_data            one-cycle strobe, no back-pressure
// config     cfg_we, cfg_index, cfg_data    written when cfg_we is high
//
// Fully pipelined: one transaction per clock, busy is always low.
// The scaling divide is a restoring divider with one quotient bit per stage,
// which sets the pipeline depth.
// rst_n (synchronous) clears valid bits and loads register defaults.
// The receiver cannot stall; results leave on the cycle they finish.
module nearest_neighbor_blit_address #(
  parameter int MAX_DIMENSION = nnba_pkg::MAX_DIMENSION_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  nnba_pkg::in_t                    in_data,
  output logic                             out_valid,
  output nnba_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [nnba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [nnba_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nnba_pkg::*;

  localparam int DW  = $clog2(MAX_DIMENSION + 1);  // saturated dimension
  localparam int QW  = $clog2(MAX_DIMENSION);      // quotient, below source dim
  localparam int NW  = COORD_W + DW;               // coord * source dim
  localparam int PW  = OFFSET_W + DW;              // canvas row * pitch
  localparam int SPW = QW + DW;                    // source row * pitch

  function automatic logic [DW-1:0] sat_dim(input logic [DIM_REG_W-1:0] v);
    logic [DW-1:0] res;
    if (v == '0) begin
      res = DW'(1);
    end else if (32'(v) > 32'(MAX_DIMENSION)) begin
      res = DW'(MAX_DIMENSION);
    end else begin
      res = DW'(v);
    end
    return res;
  endfunction

  // configuration, dimensions stored already saturated
  logic [DW-1:0]              sw_r, sh_r, dw_r, dh_r, cw_r, ch_r;
  logic signed [OFFSET_W-1:0] ox_r, oy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= DW'(1);
      sh_r <= DW'(1);
      dw_r <= DW'(1);
      dh_r <= DW'(1);
      cw_r <= DW'(1);
      ch_r <= DW'(1);
      ox_r <= '0;
      oy_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  sw_r <= sat_dim(cfg_data[DIM_REG_W-1:0]);
        REG_SOURCE_HEIGHT: sh_r <= sat_dim(cfg_data[DIM_REG_W-1:0]);
        REG_DEST_WIDTH:    dw_r <= sat_dim(cfg_data[DIM_REG_W-1:0]);
        REG_DEST_HEIGHT:   dh_r <= sat_dim(cfg_data[DIM_REG_W-1:0]);
        REG_OFFSET_X:      ox_r <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_OFFSET_Y:      oy_r <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_CANVAS_WIDTH:  cw_r <= sat_dim(cfg_data[DIM_REG_W-1:0]);
        REG_CANVAS_HEIGHT: ch_r <= sat_dim(cfg_data[DIM_REG_W-1:0]);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------- stage 1: capture, canvas coordinates
  logic                      v1_r;
  logic [COORD_W-1:0]        col1_r, row1_r;
  logic signed [OFFSET_W:0]  cx1_r, cy1_r;
  logic signed [OFFSET_W:0]  cx_nxt, cy_nxt;

  always_comb begin
    cx_nxt = (OFFSET_W+1)'(ox_r) + $signed({3'b000, in_data.column});
    cy_nxt = (OFFSET_W+1)'(oy_r) + $signed({3'b000, in_data.row});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    col1_r <= in_data.column;
    row1_r <= in_data.row;
    cx1_r  <= cx_nxt;
    cy1_r  <= cy_nxt;
  end

  // ---------------- stage 2 (divider stage 0): products, clamps, clipping
  logic [NW-1:0] nc_nxt, nr_nxt;
  logic          inside_nxt;

  always_comb begin
    nc_nxt     = NW'(col1_r) * NW'(sw_r);
    nr_nxt     = NW'(row1_r) * NW'(sh_r);
    inside_nxt = !cx1_r[OFFSET_W] && !cy1_r[OFFSET_W] &&
                 (32'(cx1_r[OFFSET_W-1:0]) < 32'(cw_r)) &&
                 (32'(cy1_r[OFFSET_W-1:0]) < 32'(ch_r));
  end

  // divider pipeline, index k = stage after k quotient steps
  logic          dv_r   [QW+1];
  logic [DW-1:0] rc_r   [QW+1];
  logic [DW-1:0] rr_r   [QW+1];
  logic [QW-1:0] loc_r  [QW+1];
  logic [QW-1:0] lor_r  [QW+1];
  logic [QW-1:0] qc_r   [QW+1];
  logic [QW-1:0] qr_r   [QW+1];
  logic          clc_r  [QW+1];  // column at or beyond dest width
  logic          clr_r  [QW+1];
  logic [PW-1:0]       dprod_r;
  logic [OFFSET_W-1:0] dcx_r;
  logic                din_r;
  logic [IDX_W-1:0]    didx_r [QW];
  logic                dwe_r  [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else begin
      dv_r[0] <= v1_r;
      for (int k = 1; k <= QW; k++) begin
        dv_r[k] <= dv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dprod_r  <= PW'(cy1_r[OFFSET_W-1:0]) * PW'(cw_r);
    dcx_r    <= cx1_r[OFFSET_W-1:0];
    din_r    <= inside_nxt;
  end

  // one restoring step per stage for both coordinates
  logic [DW:0]   tc [QW], tr [QW];
  logic          gec [QW], ger [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      tc[k]  = {rc_r[k], loc_r[k][QW-1]};
      tr[k]  = {rr_r[k], lor_r[k][QW-1]};
      gec[k] = tc[k] >= {1'b0, dw_r};
      ger[k] = tr[k] >= {1'b0, dh_r};
    end
  end

  always_ff @(posedge clk) begin
    rc_r[0]  <= DW'(nc_nxt[NW-1:QW]);
    rr_r[0]  <= DW'(nr_nxt[NW-1:QW]);
    loc_r[0] <= nc_nxt[QW-1:0];
    lor_r[0] <= nr_nxt[QW-1:0];
    qc_r[0]  <= '0;
    qr_r[0]  <= '0;
    clc_r[0] <= 32'(col1_r) >= 32'(dw_r);
    clr_r[0] <= 32'(row1_r) >= 32'(dh_r);
    for (int k = 1; k <= QW; k++) begin
      rc_r[k]  <= gec[k-1] ? DW'(tc[k-1] - {1'b0, dw_r}) : DW'(tc[k-1]);
      rr_r[k]  <= ger[k-1] ? DW'(tr[k-1] - {1'b0, dh_r}) : DW'(tr[k-1]);
      loc_r[k] <= loc_r[k-1] << 1;
      lor_r[k] <= lor_r[k-1] << 1;
      qc_r[k]  <= {qc_r[k-1][QW-2:0], gec[k-1]};
      qr_r[k]  <= {qr_r[k-1][QW-2:0], ger[k-1]};
      clc_r[k] <= clc_r[k-1];
      clr_r[k] <= clr_r[k-1];
    end
    didx_r[0] <= din_r ? IDX_W'(dprod_r + PW'(dcx_r)) : '0;
    dwe_r[0]  <= din_r;
    for (int k = 1; k < QW; k++) begin
      didx_r[k] <= didx_r[k-1];
      dwe_r[k]  <= dwe_r[k-1];
    end
  end

  // ---------------- clamp and source row product
  logic             vs_r;
  logic [SPW-1:0]   sprod_r;
  logic [QW-1:0]    sc_r;
  logic [IDX_W-1:0] sdidx_r;
  logic             swe_r;
  logic [QW-1:0]    sc_nxt, sr_nxt;

  always_comb begin
    sc_nxt = clc_r[QW] ? QW'(sw_r - DW'(1)) : qc_r[QW];
    sr_nxt = clr_r[QW] ? QW'(sh_r - DW'(1)) : qr_r[QW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vs_r      <= dv_r[QW];
      out_valid <= vs_r;
    end
  end

  always_ff @(posedge clk) begin
    sprod_r <= SPW'(sr_nxt) * SPW'(sw_r);
    sc_r    <= sc_nxt;
    sdidx_r <= didx_r[QW-1];
    swe_r   <= dwe_r[QW-1];
    out_data.source_index <= IDX_W'(sprod_r + SPW'(sc_r));
    out_data.dest_index   <= sdidx_r;
    out_data.write_enable <= swe_r;
  end

endmodule

@@ tb/tb_nearest_neighbor_blit_address.sv @@
module tb_nearest_neighbor_blit_address;
  import nnba_pkg::*;

  localparam int LATENCY     = $clog2(MAX_DIMENSION_DEF) + 4;
  localparam int CYCLE_LIMIT = 400000;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   start     = 1'b0;
  logic                   busy;
  in_t                    in_data   = '0;
  logic                   out_valid;
  out_t                   out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // register values as written to the block, before saturation
  logic [CFG_DATA_W-1:0] shadow_reg [8];

  in_t  pixel_queue[$];
  out_t pending_addresses[$];
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  bit   allow_gaps     = 1'b1;
  int   gap_left       = 0;

  nearest_neighbor_blit_address DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // zero and oversize dimensions saturate to 1..MAX_DIMENSION
  function automatic longint clamp_dim(logic [DIM_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIMENSION_DEF) return MAX_DIMENSION_DEF;
    return longint'(v);
  endfunction

  function automatic out_t map_pixel(in_t px);
    longint sw, sh, dw, dh, cw, ch;
    longint src_col, src_row, cx, cy;
    out_t   r;
    sw = clamp_dim(shadow_reg[REG_SOURCE_WIDTH][DIM_REG_W-1:0]);
    sh = clamp_dim(shadow_reg[REG_SOURCE_HEIGHT][DIM_REG_W-1:0]);
    dw = clamp_dim(shadow_reg[REG_DEST_WIDTH][DIM_REG_W-1:0]);
    dh = clamp_dim(shadow_reg[REG_DEST_HEIGHT][DIM_REG_W-1:0]);
    cw = clamp_dim(shadow_reg[REG_CANVAS_WIDTH][DIM_REG_W-1:0]);
    ch = clamp_dim(shadow_reg[REG_CANVAS_HEIGHT][DIM_REG_W-1:0]);
    src_col = longint'(px.column) * sw / dw;
    if (src_col > sw - 1) src_col = sw - 1;
    src_row = longint'(px.row) * sh / dh;
    if (src_row > sh - 1) src_row = sh - 1;
    cx = longint'($signed(shadow_reg[REG_OFFSET_X])) + longint'(px.column);
    cy = longint'($signed(shadow_reg[REG_OFFSET_Y])) + longint'(px.row);
    r.source_index = IDX_W'(src_row * sw + src_col);
    r.write_enable = (cx >= 0 && cy >= 0 && cx < cw && cy < ch);
    r.dest_index   = r.write_enable ? IDX_W'(cy * cw + cx) : '0;
    return r;
  endfunction

  function automatic void add_pixel(int col, int row);
    in_t px;
    px.column = COORD_W'(col);
    px.row    = COORD_W'(row);
    pixel_queue = {pixel_queue, px};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0:       return CFG_DATA_W'(MAX_DIMENSION_DEF);
      1:       return {1'($urandom), 14'd0};
      2:       return CFG_DATA_W'($urandom);
      3:       return CFG_DATA_W'(1);
      4, 5:    return CFG_DATA_W'($urandom_range(1, 400));
      default: return CFG_DATA_W'($urandom_range(1, 24));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 7))
      0:       return CFG_DATA_W'($urandom);
      1:       return CFG_DATA_W'(-MAX_DIMENSION_DEF);
      2:       return CFG_DATA_W'(MAX_DIMENSION_DEF);
      default: return CFG_DATA_W'(int'($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  // mostly inside the rectangle, some just past it, some anywhere
  function automatic logic [COORD_W-1:0] pick_coord(logic [CFG_DATA_W-1:0] dim);
    longint lim;
    lim = clamp_dim(dim[DIM_REG_W-1:0]);
    case ($urandom_range(0, 9))
      0:       return COORD_W'($urandom);
      1:       return $urandom_range(0, 1) ? '1 : '0;
      2:       return (lim < 8192) ? COORD_W'(lim) : '1;
      default: return COORD_W'($urandom_range(0, int'(lim) - 1));
    endcase
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || start || pending_addresses.size() != 0);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] sw, sh, dw, dh, ox, oy, cw, ch);
    logic [CFG_DATA_W-1:0] vals [8];
    cfg_reg_t              r;
    vals = '{sw, sh, dw, dh, ox, oy, cw, ch};
    wait_idle();
    @(posedge clk);
    r = r.first();
    repeat (8) begin
      cfg_we    <= 1'b1;
      cfg_index <= r;
      cfg_data  <= vals[r];
      @(posedge clk);
      shadow_reg[r] = vals[r];
      r = r.next();
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // driver: a new transaction goes out once the previous one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left = 0;
    end else if (!start || !busy) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        start    <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        start   <= 1'b1;
        in_data <= pixel_queue.pop_front();
        if (allow_gaps && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 17);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on acceptance, check on every result strobe
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (start && !busy) pending_addresses = {pending_addresses, map_pixel(in_data)};
      if (out_valid) begin
        if (pending_addresses.size() == 0) begin
          $error("unexpected result: source_index %0d dest_index %0d write_enable %0d",
                 out_data.source_index, out_data.dest_index, out_data.write_enable);
          mismatch_count++;
        end else begin
          want = pending_addresses.pop_front();
          if (out_data.source_index !== want.source_index) begin
            $error("source_index: expected %0d, got %0d", want.source_index,
                   out_data.source_index);
            mismatch_count++;
          end
          if (out_data.dest_index !== want.dest_index) begin
            $error("dest_index: expected %0d, got %0d", want.dest_index, out_data.dest_index);
            mismatch_count++;
          end
          if (out_data.write_enable !== want.write_enable) begin
            $error("write_enable: expected %0d, got %0d", want.write_enable,
                   out_data.write_enable);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int       n;
    cfg_reg_t r;
    r = r.first();
    repeat (8) begin
      shadow_reg[r] = (r == REG_OFFSET_X || r == REG_OFFSET_Y) ? '0 : CFG_DATA_W'(1);
      r = r.next();
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: 1x1 everything, coordinates past the rectangle still clamp
    add_pixel(0, 0);
    add_pixel('1, '1);
    add_pixel(0, '1);
    add_pixel('1, 0);

    // zero and oversize dimensions, offsets at the ends of their range
    program_regs(15'h0000, 15'h3FFF, 15'h7FFF, 15'h4000,
                 15'h4000, 15'h3FFF, CFG_DATA_W'(8192), 15'h0000);
    add_pixel('1, '1);
    add_pixel(0, 0);
    add_pixel(100, 3);

    // largest sizes, largest indices
    program_regs(CFG_DATA_W'(8192), CFG_DATA_W'(8192), CFG_DATA_W'(8192), CFG_DATA_W'(8192),
                 '0, '0, CFG_DATA_W'(8192), CFG_DATA_W'(8192));
    add_pixel('1, '1);
    add_pixel(0, 0);
    add_pixel(4096, 1);
    add_pixel('1, 0);

    // clipping on each canvas edge, upscale in x, downscale in y
    program_regs(CFG_DATA_W'(3), CFG_DATA_W'(5), CFG_DATA_W'(7), CFG_DATA_W'(2),
                 CFG_DATA_W'(-5), CFG_DATA_W'(-3), CFG_DATA_W'(10), CFG_DATA_W'(7));
    add_pixel(4, 2);
    add_pixel(5, 3);
    add_pixel(14, 9);
    add_pixel(15, 3);
    add_pixel(4, 10);
    add_pixel(0, 0);
    add_pixel(6, 1);

    for (int p = 0; p < 24; p++) begin
      program_regs(pick_dim(), pick_dim(), pick_dim(), pick_dim(),
                   pick_offset(), pick_offset(), pick_dim(), pick_dim());
      allow_gaps = (p < 20) && ($urandom_range(0, 3) != 0);
      n = $urandom_range(40, 80);
      repeat (n) add_pixel(int'(pick_coord(shadow_reg[REG_DEST_WIDTH])),
                           int'(pick_coord(shadow_reg[REG_DEST_HEIGHT])));
    end

    wait_idle();
    repeat (LATENCY + 8) @(negedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/nnba_pkg.sv
hw/rtl/nearest_neighbor_blit_address.sv
tb/tb_nearest_neighbor_blit_address.sv
